// File: rtl/mbrr_pkg.sv
// Shared types, codes and the CRC byte update for the response receiver.
// Has no dependencies; every other file of the block imports it.
package mbrr_pkg;

  localparam int BufferBytesDef = 64;
  localparam int FrameLenW      = 9;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 8;

  // Input kinds carried in the stream user bit.
  localparam logic OpByte    = 1'b0;
  localparam logic OpTimeout = 1'b1;

  // Result kinds.
  localparam logic KindRead  = 1'b0;
  localparam logic KindWrite = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSlaveAddr = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExpFunc   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgReqRegs   = 2'd2;

  // Modbus function codes.
  localparam logic [7:0] FuncRead       = 8'h03;
  localparam logic [7:0] FuncWriteMulti = 8'h10;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic [7:0] slave_addr;
    logic [7:0] exp_func;
    logic [6:0] req_regs;
  } cfg_t;

  typedef struct packed {
    logic        frame_good;
    logic        frame_kind;
    logic [15:0] attr_max;
    logic [15:0] attr_min;
    logic [15:0] attr_decimal;
  } res_t;

  // Reflected CRC-16/Modbus update over one byte, low bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/mbrr_frame_ctrl.sv
// Frame tracking state of the response receiver: position, length, CRC and
// attribute bytes, updated once per accepted word. Depends on mbrr_pkg.
module mbrr_frame_ctrl #(
  parameter int BUFFER_BYTES = mbrr_pkg::BufferBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbrr_pkg::cfg_t     cfg_i,
  input  logic               fire_i,
  input  logic               opcode_i,
  input  logic [7:0]         rx_byte_i,
  output mbrr_pkg::res_t     res_o
);
  import mbrr_pkg::*;

  localparam int PosW = $clog2(BUFFER_BYTES + 1);
  localparam int CmpW = ((PosW > FrameLenW) ? PosW : FrameLenW) + 1;

  logic [PosW-1:0]      pos_q, pos_d;
  logic [FrameLenW-1:0] flen_q, flen_d;
  logic [15:0]          crc_q, crc_d;
  logic [7:0]           rfunc_q, rfunc_d;
  logic [7:0]           attr_q [6];
  logic [7:0]           attr_d [6];

  always_comb begin
    logic [PosW-1:0] p;
    logic [CmpW-1:0] pinc;
    logic [CmpW-1:0] flen_ext;
    logic            good;
    logic            kind;
    p        = '0;
    pinc     = '0;
    flen_ext = '0;
    good     = 1'b0;
    kind     = KindRead;
    pos_d    = pos_q;
    flen_d   = flen_q;
    crc_d    = crc_q;
    rfunc_d  = rfunc_q;
    attr_d   = attr_q;
    if (opcode_i == OpTimeout) begin
      pos_d  = '0;
      flen_d = '0;
    end else begin
      // A position at the buffer end starts over with this byte.
      p        = (pos_q >= PosW'(BUFFER_BYTES)) ? '0 : pos_q;
      crc_d    = crc_byte((p == '0) ? CrcInit : crc_q, rx_byte_i);
      rfunc_d  = (p == PosW'(1)) ? rx_byte_i : rfunc_q;
      for (int i = 0; i < 6; i++) begin
        if (p == PosW'(5 + i)) begin
          attr_d[i] = rx_byte_i;
        end
      end
      pinc     = CmpW'(p) + CmpW'(1);
      flen_ext = CmpW'(flen_q);
      priority if (p == '0) begin
        pos_d = (rx_byte_i == cfg_i.slave_addr) ? PosW'(1) : '0;
      end else if (p == PosW'(1)) begin
        pos_d = (rx_byte_i == cfg_i.exp_func) ? PosW'(2) : '0;
      end else if (rfunc_d == FuncWriteMulti) begin
        if (p <= PosW'(6)) begin
          pos_d = PosW'(pinc);
        end else if (p == PosW'(7)) begin
          good  = 1'b1;
          kind  = KindWrite;
          pos_d = '0;
        end else begin
          pos_d = '0;
        end
      end else if (rfunc_d == FuncRead) begin
        if (p == PosW'(2)) begin
          if (rx_byte_i == {cfg_i.req_regs, 1'b0}) begin
            pos_d  = PosW'(3);
            flen_d = FrameLenW'(rx_byte_i) + FrameLenW'(5);
          end else begin
            pos_d = '0;
          end
        end else if (pinc == flen_ext) begin
          if (crc_d == 16'h0000) begin
            good  = 1'b1;
            pos_d = PosW'(pinc);
          end else begin
            pos_d = '0;
          end
        end else if (pinc > flen_ext + CmpW'(1)) begin
          pos_d = '0;
        end else begin
          // Also covers the byte that lingers one past a good read frame.
          pos_d = PosW'(pinc);
        end
      end else begin
        pos_d = '0;
      end
    end
    res_o = '0;
    if (good) begin
      res_o.frame_good   = 1'b1;
      res_o.frame_kind   = kind;
      res_o.attr_max     = {attr_d[0], attr_d[1]};
      res_o.attr_min     = {attr_d[2], attr_d[3]};
      res_o.attr_decimal = {attr_d[4], attr_d[5]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      flen_q  <= '0;
      crc_q   <= CrcInit;
      rfunc_q <= '0;
      for (int i = 0; i < 6; i++) begin
        attr_q[i] <= '0;
      end
    end else if (fire_i) begin
      pos_q   <= pos_d;
      flen_q  <= flen_d;
      crc_q   <= crc_d;
      rfunc_q <= rfunc_d;
      attr_q  <= attr_d;
    end
  end

  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (opcode_i == OpTimeout) |=> (pos_q == '0) && (flen_q == '0))
    else $error("position not cleared after idle timeout");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(BUFFER_BYTES))
    else $error("position beyond buffer end");

  a_good_read_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.frame_good && (res_o.frame_kind == KindRead) |-> (crc_d == 16'h0000))
    else $error("read frame reported good with non-zero CRC residue");

endmodule

// File: rtl/mbrr_out_reg.sv
// Output register of the response receiver: holds one result word and
// drives the stream ready of the input side. Depends on mbrr_pkg.
module mbrr_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mbrr_pkg::res_t res_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mbrr_pkg::res_t res_o
);
  import mbrr_pkg::*;

  logic valid_q;
  res_t res_q;
  logic fire;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_i;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> valid_q)
    else $error("input stalled with empty output register");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_ready_i && !in_valid_i |=> !valid_q)
    else $error("output register did not empty after delivery");

  a_bad_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.frame_good |-> (res_q.frame_kind == KindRead) &&
      (res_q.attr_max == '0) && (res_q.attr_min == '0) && (res_q.attr_decimal == '0))
    else $error("non-frame result carries non-zero fields");

endmodule

// File: rtl/modbus_response_receiver.sv
// Top level of the Modbus RTU response receiver: configuration registers,
// frame tracking and output register. Depends on mbrr_pkg, mbrr_frame_ctrl
// and mbrr_out_reg.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata rx_byte, tuser opcode
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata attributes, tuser flags
//  cfg       in         cfg_we_i (no back-pressure)    cfg_idx_i, cfg_wdata_i
//
// For an accepted word, the CRC byte update, the frame position decision and
// the attribute capture all sit between the state registers and the output
// register, and the result is visible the cycle after acceptance. A new word
// is taken in every cycle while the result word is taken or the output
// register is empty. Reset is asynchronous and active low; it clears the
// frame state and empties the output register.
// A stall on the master side holds the result and stalls the slave side.
module modbus_response_receiver #(
  parameter int BUFFER_BYTES = mbrr_pkg::BufferBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
  input  logic                         s_axis_tuser,   // [0] opcode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [15:0] attr_max, [31:16] attr_min, [47:32] attr_decimal
  output logic [47:0]                  m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,   // [0] frame_good, [1] frame_kind
  input  logic                         cfg_we_i,
  input  logic [mbrr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mbrr_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import mbrr_pkg::*;

  cfg_t cfg_q;
  res_t res_next;
  res_t res_out;
  logic fire;

  // Configuration is to be written by the user only between exchanges; the block
  // does not enforce it. An index beyond the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_addr <= 8'h00;
      cfg_q.exp_func   <= FuncRead;
      cfg_q.req_regs   <= 7'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSlaveAddr: cfg_q.slave_addr <= cfg_wdata_i;
        CfgExpFunc:   cfg_q.exp_func   <= cfg_wdata_i;
        CfgReqRegs:   cfg_q.req_regs   <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // A word is accepted when the output register can take its result.
  assign fire = s_axis_tvalid && s_axis_tready;

  mbrr_frame_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_frame_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .fire_i   (fire),
    .opcode_i (s_axis_tuser),
    .rx_byte_i(s_axis_tdata),
    .res_o    (res_next)
  );

  // One result word per accepted input word, timeouts included.
  mbrr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .res_i      (res_next),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .res_o      (res_out)
  );

  assign m_axis_tdata = {res_out.attr_decimal, res_out.attr_min, res_out.attr_max};
  assign m_axis_tuser = {res_out.frame_kind, res_out.frame_good};

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Modbus RTU response receiver: drives response
// frames, timeouts and noise, predicts every result word and compares it.
// Depends on mbrr_pkg and modbus_response_receiver.
module testbench;
  import mbrr_pkg::*;

  localparam int BufferBytes   = BufferBytesDef;
  localparam int ItemTarget    = 1900;   // random words to send
  localparam int PhaseWords    = 150;    // words per configuration phase
  localparam int IdlePct       = 31;     // chance of an idle cycle on either side
  localparam int DrainCycles   = 4;      // margin after the last predicted result
  localparam int WatchdogLimit = 1000;   // cycles with no word moving on either side

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;    // [7:0] rx_byte
  logic                s_axis_tuser;    // [0] opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [15:0] attr_max, [31:16] attr_min, [47:32] attr_decimal
  logic [47:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;    // [0] frame_good, [1] frame_kind
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  modbus_response_receiver #(
    .BUFFER_BYTES(BufferBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Shadow of the receiver: configuration and frame tracking state.
  cfg_t        cfg_shadow;
  logic [8:0]  frame_pos;
  logic [8:0]  frame_len;
  logic [15:0] crc_acc;
  logic [7:0]  rx_func;
  logic [7:0]  attr_bytes [6];

  res_t        expected_replies [$];   // one predicted result per accepted word
  logic [7:0]  frame_buf [$];          // frame being assembled for sending
  int          items_sent;
  int          error_count;
  int          src_idle_pct;
  int          sink_stall_pct;

  // The clock runs free with a 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The result side takes words at random, stalling in roughly a third of the
  // cycles unless a phase has switched stalling off.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // CRC-16/Modbus, fed one bit at a time from the least significant end.
  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Advances the shadow receiver by one accepted word and returns the result
  // word that the block must produce for it.
  function automatic res_t predict_reply(input logic op, input logic [7:0] b);
    res_t r;
    logic done;
    r    = '0;
    done = 1'b0;
    if (op == OpTimeout) begin
      frame_pos = '0;
      frame_len = '0;
      return r;
    end
    // A byte beyond the buffer is taken as the first byte of a new frame.
    if (frame_pos >= BufferBytes) begin
      frame_pos = '0;
    end
    crc_acc = crc16_update((frame_pos == 0) ? CrcInit : crc_acc, b);
    if (frame_pos == 1) begin
      rx_func = b;
    end
    // Bytes 5 to 10 always land in the attribute store, even past a frame end.
    if (frame_pos >= 5 && frame_pos <= 10) begin
      attr_bytes[3'(frame_pos - 9'd5)] = b;
    end
    if (frame_pos == 0) begin
      frame_pos = (b == cfg_shadow.slave_addr) ? 9'd1 : 9'd0;
    end else if (frame_pos == 1) begin
      frame_pos = (b == cfg_shadow.exp_func) ? 9'd2 : 9'd0;
    end else if (rx_func == FuncWriteMulti) begin
      if (frame_pos <= 6) begin
        frame_pos++;
      end else if (frame_pos == 7) begin
        done         = 1'b1;
        r.frame_kind = KindWrite;
        frame_pos    = '0;
      end else begin
        frame_pos = '0;
      end
    end else if (rx_func == FuncRead) begin
      if (frame_pos == 2) begin
        if (b == {cfg_shadow.req_regs, 1'b0}) begin
          frame_pos = 9'd3;
          frame_len = {1'b0, b} + 9'd5;
        end else begin
          frame_pos = '0;
        end
      end else begin
        frame_pos++;
        if (frame_pos == frame_len) begin
          // A good read frame leaves the position at the frame end.
          if (crc_acc == 16'h0000) begin
            done         = 1'b1;
            r.frame_kind = KindRead;
          end else begin
            frame_pos = '0;
          end
        end else if (frame_pos > frame_len + 9'd1) begin
          frame_pos = '0;
        end
      end
    end else begin
      frame_pos = '0;
    end
    if (done) begin
      r.frame_good   = 1'b1;
      r.attr_max     = {attr_bytes[0], attr_bytes[1]};
      r.attr_min     = {attr_bytes[2], attr_bytes[3]};
      r.attr_decimal = {attr_bytes[4], attr_bytes[5]};
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  // Every word taken on the input side gets its prediction queued here.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_replies.push_back(predict_reply(s_axis_tuser, s_axis_tdata));
    end
  end

  // Every result word taken on the output side is held against the oldest
  // prediction, field by field.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("result word with no input word waiting for it");
      end else begin
        want = expected_replies.pop_front();
        check_field("frame_good", 16'(m_axis_tuser[0]), 16'(want.frame_good));
        check_field("frame_kind", 16'(m_axis_tuser[1]), 16'(want.frame_kind));
        check_field("attr_max", m_axis_tdata[15:0], want.attr_max);
        check_field("attr_min", m_axis_tdata[31:16], want.attr_min);
        check_field("attr_decimal", m_axis_tdata[47:32], want.attr_decimal);
      end
    end
  end

  // The run is abandoned once nothing has moved on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("testbench failed");
    $finish;
  end

  // Sends one word, idling first at random. tvalid is left high on return so
  // that a following word can go out back to back.
  task automatic send_word(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  // The byte field of a timeout carries junk on purpose: it must be ignored.
  task automatic send_timeout();
    send_word(OpTimeout, 8'($urandom_range(255)));
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) begin
      send_word(OpByte, frame_buf[i]);
    end
  endtask

  // Stops sending and waits until every predicted result has been taken,
  // then waits out DrainCycles for anything the block might still put out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgSlaveAddr: cfg_shadow.slave_addr = val;
      CfgExpFunc:   cfg_shadow.exp_func   = val;
      CfgReqRegs:   cfg_shadow.req_regs   = val[6:0];
      default: ;
    endcase
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic set_config(input logic [7:0] addr, input logic [7:0] func,
                            input logic [6:0] regs);
    wait_idle();
    write_reg(CfgSlaveAddr, addr);
    write_reg(CfgExpFunc, func);
    write_reg(CfgReqRegs, {1'b0, regs});
    cfg_we_i <= 1'b0;
  endtask

  // Read reply: address, function, byte count, register data, CRC low then high.
  task automatic build_read_reply(input logic [7:0] addr, input logic [7:0] func,
                                  input logic [6:0] nregs);
    logic [15:0] crc;
    frame_buf = {};
    frame_buf.push_back(addr);
    frame_buf.push_back(func);
    frame_buf.push_back({nregs, 1'b0});
    repeat (2 * nregs) frame_buf.push_back(8'($urandom_range(255)));
    crc = CrcInit;
    foreach (frame_buf[i]) begin
      crc = crc16_update(crc, frame_buf[i]);
    end
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endtask

  // Write-multiple acknowledge: eight bytes, the last six random.
  task automatic build_write_ack(input logic [7:0] addr);
    frame_buf = {};
    frame_buf.push_back(addr);
    frame_buf.push_back(FuncWriteMulti);
    repeat (6) frame_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic flip_random_bit();
    int idx;
    int bitpos;
    idx    = $urandom_range(frame_buf.size() - 1);
    bitpos = $urandom_range(7);
    frame_buf[idx][bitpos] = ~frame_buf[idx][bitpos];
  endtask

  // Read replies: a minimal good frame, bytes after it while the position
  // lingers, a frame with a broken CRC and one with a wrong byte count.
  task automatic test_read_replies();
    set_config(8'hFF, FuncRead, 7'd0);
    send_timeout();
    build_read_reply(8'hFF, FuncRead, 7'd0);
    send_frame();
    send_word(OpByte, 8'hFF);
    send_word(OpByte, 8'h00);
    build_read_reply(8'hFF, FuncRead, 7'd0);
    frame_buf[frame_buf.size() - 1][0] = ~frame_buf[frame_buf.size() - 1][0];
    send_frame();
    send_word(OpByte, 8'hFF);
    send_word(OpByte, FuncRead);
    send_word(OpByte, 8'h02);
  endtask

  // A write acknowledge is only eight bytes, so attr_decimal and the low half
  // of attr_min come from whatever sat in the store before.
  task automatic test_write_ack();
    set_config(8'h00, FuncWriteMulti, 7'd127);
    send_timeout();
    build_write_ack(8'h00);
    foreach (frame_buf[i]) begin
      if (i >= 2) frame_buf[i] = 8'hFF;
    end
    send_frame();
  endtask

  // One random stretch of traffic: mostly well-formed frames for the current
  // setting, usually behind an idle timeout, some corrupted or cut short, the
  // rest frames of the wrong kind and plain noise.
  task automatic send_random_unit();
    int pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 85) begin
      send_timeout();
    end
    if (pick < 70) begin
      if (cfg_shadow.exp_func == FuncWriteMulti) begin
        build_write_ack(cfg_shadow.slave_addr);
      end else begin
        build_read_reply(cfg_shadow.slave_addr, cfg_shadow.exp_func,
                         (cfg_shadow.exp_func == FuncRead) ? cfg_shadow.req_regs :
                         7'($urandom_range(6)));
      end
    end else if (pick < 80) begin
      if (cfg_shadow.exp_func == FuncWriteMulti) begin
        build_read_reply(cfg_shadow.slave_addr, FuncRead, 7'($urandom_range(6)));
      end else begin
        build_write_ack(cfg_shadow.slave_addr);
      end
    end else begin
      frame_buf = {};
      repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 20) begin
      flip_random_bit();
    end
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(frame_buf.size() - 1)) void'(frame_buf.pop_back());
    end
    send_frame();
  endtask

  // Phases of random traffic under changing settings. The first phases pin
  // the register extremes: the largest count runs past the buffer, one phase
  // has no idling on either side, and two use function codes that are unknown.
  task automatic test_random_traffic();
    int         phase;
    int         stop_at;
    int         phase_end;
    int         pick;
    logic [7:0] func;
    logic [6:0] regs;
    phase   = 0;
    stop_at = items_sent + ItemTarget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      func = (pick < 50) ? FuncRead : (pick < 85) ? FuncWriteMulti : 8'($urandom_range(255));
      regs = ($urandom_range(99) < 85) ? 7'($urandom_range(6)) : 7'($urandom_range(127));
      case (phase)
        0:       set_config(8'h00, FuncRead, 7'd127);
        1:       set_config(8'hFF, FuncWriteMulti, 7'd0);
        2:       set_config(8'($urandom_range(255)), 8'h00, regs);
        3:       set_config(8'($urandom_range(255)), 8'hFF, regs);
        default: set_config(8'($urandom_range(255)), func, regs);
      endcase
      src_idle_pct   = (phase == 1) ? 0 : IdlePct;
      sink_stall_pct = (phase == 1) ? 0 : IdlePct;
      phase_end = items_sent + PhaseWords;
      while (items_sent < phase_end && items_sent < stop_at) begin
        send_random_unit();
      end
      phase++;
    end
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OpByte;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgSlaveAddr;
    cfg_wdata_i   <= '0;
    rst_ni        <= 1'b0;
    cfg_shadow.slave_addr = 8'h00;
    cfg_shadow.exp_func   = FuncRead;
    cfg_shadow.req_regs   = 7'd3;
    frame_pos      = '0;
    frame_len      = '0;
    crc_acc        = CrcInit;
    rx_func        = '0;
    foreach (attr_bytes[i]) attr_bytes[i] = '0;
    items_sent     = 0;
    error_count    = 0;
    src_idle_pct   = IdlePct;
    sink_stall_pct = IdlePct;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_read_replies();
    test_write_ack();
    test_random_traffic();

    wait_idle();
    if (expected_replies.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
    end
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
